// ===== rtl/core/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types, codes and defaults of the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int CAPACITY_DEF   = 256;
    localparam int VALUE_BITS_DEF = 16;

    localparam logic [2:0] KIND_READ   = 3'd0;
    localparam logic [2:0] KIND_FRONT  = 3'd1;
    localparam logic [2:0] KIND_APPEND = 3'd2;
    localparam logic [2:0] KIND_INSERT = 3'd3;
    localparam logic [2:0] KIND_DELETE = 3'd4;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  position;
        logic [15:0] value;
    } item_in_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        found;
        logic [1:0]  status;
        logic [8:0]  entry_count;
    } item_out_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic load_ptr;
        logic rd_pos;
        logic shift_rd;
        logic wr_value;
        logic finish;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic read_ok;
        logic error;
        logic insert;
        logic shift_empty;
        logic ptr_at_end;
    } dp_status_t;

endpackage

// ===== rtl/core/indexed_list_store.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list of up to CAPACITY values with read, insert and delete by
// position.
//
// Usage: drive item and raise start; the item is taken on a clock edge
// where start is high and busy is low. Exactly one result follows, shown
// on result for a single cycle with done high; the receiver cannot stall,
// so it must capture the result in that cycle. done comes in a cycle with
// busy low, so the next item can be started in the same cycle.
// Steps from the accepting edge to done: a read passes decode and a read
// wait; a refused or invalid item ends in decode; an insert or delete
// moves its entries in the shift and drain states, at most CAPACITY - 1
// of them, and an insert then writes its value in the tail state.
// Entries move one per cycle through the entry memory, one read port and
// one write port.
// Reset empties the list at once; the memory itself is not cleared.
// ----------------------------------------------------------------------------
module indexed_list_store #(
    parameter int CAPACITY   = ils_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = ils_pkg::VALUE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ils_pkg::item_in_t  item,
    output logic               done,
    output ils_pkg::item_out_t result
);
    import ils_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t st;

    ils_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .st    (st),
        .cmd   (cmd)
    );

    ils_datapath #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .st     (st),
        .done   (done),
        .result (result)
    );

endmodule

// ===== rtl/core/ils_ctrl.sv =====
// ----------------------------------------------------------------------------
// ils_ctrl
// Sequencer: acts on the datapath's decode of the captured item and steps the read, shift and write phases.
// ----------------------------------------------------------------------------
module ils_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ils_pkg::dp_status_t st,
    output ils_pkg::ctl_cmd_t   cmd
);
    import ils_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_TAIL   = 3'd4;
    localparam logic [2:0] S_RDWAIT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (st.read_ok)
                begin
                    cmd.rd_pos = 1'b1;
                    state_next = S_RDWAIT;
                end
                else if (st.error)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!st.shift_empty)
                begin
                    cmd.load_ptr = 1'b1;
                    state_next   = S_SHIFT;
                end
                else if (st.insert)
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SHIFT:
            begin
                cmd.shift_rd = 1'b1;
                if (st.ptr_at_end)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (st.insert)
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TAIL:
            begin
                cmd.wr_value = 1'b1;
                cmd.finish   = 1'b1;
                state_next   = S_IDLE;
            end
            S_RDWAIT:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/ils_datapath.sv =====
// ----------------------------------------------------------------------------
// ils_datapath
// Entry memory, count, shift pointer, decode checks and result register.
// ----------------------------------------------------------------------------
module ils_datapath #(
    parameter int CAPACITY   = ils_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = ils_pkg::VALUE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ils_pkg::item_in_t   item,
    input  ils_pkg::ctl_cmd_t   cmd,
    output ils_pkg::dp_status_t st,
    output logic                done,
    output ils_pkg::item_out_t  result
);
    import ils_pkg::*;

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;

    logic [VALUE_BITS-1:0] mem [CAPACITY];

    item_in_t              item_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [AW-1:0]         ptr_reg;
    logic [AW-1:0]         ptr_next;
    logic [AW-1:0]         rd_addr_reg;
    logic                  pend_reg;
    logic [VALUE_BITS-1:0] rd_data_reg;
    logic                  done_reg;
    item_out_t             result_reg;

    logic [CMPW-1:0]       pos_w;
    logic [CMPW-1:0]       cnt_w;
    logic [CMPW-1:0]       ins_pos_w;
    logic [CMPW-1:0]       start_w;
    logic [CMPW-1:0]       end_w;
    logic                  full;
    logic                  is_ins;
    logic                  is_del;
    logic [1:0]            status_c;

    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    item_out_t             result_c;

    assign pos_w = CMPW'(item_reg.position);
    assign cnt_w = CMPW'(count_reg);
    assign full  = (cnt_w == CMPW'(CAPACITY));

    always_comb
    begin
        status_c  = ST_DONE;
        is_ins    = 1'b0;
        is_del    = 1'b0;
        ins_pos_w = '0;
        case (item_reg.kind)
            KIND_READ:
            begin
                if (pos_w >= cnt_w)
                begin
                    status_c = ST_INVALID;
                end
            end
            KIND_FRONT:
            begin
                if (full)
                begin
                    status_c = ST_FULL;
                end
                else
                begin
                    is_ins = 1'b1;
                end
            end
            KIND_APPEND:
            begin
                ins_pos_w = cnt_w;
                if (full)
                begin
                    status_c = ST_FULL;
                end
                else
                begin
                    is_ins = 1'b1;
                end
            end
            KIND_INSERT:
            begin
                ins_pos_w = pos_w;
                if (pos_w > cnt_w)
                begin
                    status_c = ST_INVALID;
                end
                else if (full)
                begin
                    status_c = ST_FULL;
                end
                else
                begin
                    is_ins = 1'b1;
                end
            end
            KIND_DELETE:
            begin
                if (pos_w < cnt_w)
                begin
                    is_del = 1'b1;
                end
                else
                begin
                    status_c = ST_INVALID;
                end
            end
            default:
            begin
                status_c = ST_INVALID;
            end
        endcase
    end

    // insert moves count-1 down to the insert position up by one;
    // delete moves position+1 up to count-1 down by one
    assign start_w = is_ins ? (cnt_w - CMPW'(1)) : (pos_w + CMPW'(1));
    assign end_w   = is_ins ? ins_pos_w : (cnt_w - CMPW'(1));

    assign st.read_ok     = (item_reg.kind == KIND_READ) && (status_c == ST_DONE);
    assign st.error       = (status_c != ST_DONE);
    assign st.insert      = is_ins;
    assign st.shift_empty = is_ins ? (ins_pos_w == cnt_w) : (start_w == cnt_w);
    assign st.ptr_at_end  = (ptr_reg == end_w[AW-1:0]);

    assign ptr_next = cmd.load_ptr ? start_w[AW-1:0]
                    : (is_ins ? ptr_reg - AW'(1) : ptr_reg + AW'(1));

    assign rd_en   = cmd.rd_pos | cmd.shift_rd;
    assign rd_addr = cmd.rd_pos ? pos_w[AW-1:0] : ptr_reg;
    assign wr_en   = pend_reg | cmd.wr_value;
    assign wr_addr = cmd.wr_value ? ins_pos_w[AW-1:0]
                   : (is_ins ? rd_addr_reg + AW'(1) : rd_addr_reg - AW'(1));
    assign wr_data = cmd.wr_value ? VALUE_BITS'(item_reg.value) : rd_data_reg;

    always_comb
    begin
        count_next = count_reg;
        if (status_c == ST_DONE)
        begin
            if (is_ins)
            begin
                count_next = count_reg + CW'(1);
            end
            else if (is_del)
            begin
                count_next = count_reg - CW'(1);
            end
        end
        result_c.read_data   = st.read_ok ? 16'(rd_data_reg) : 16'd0;
        result_c.found       = st.read_ok;
        result_c.status      = status_c;
        result_c.entry_count = 9'(count_next);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (cmd.load_ptr | cmd.shift_rd)
        begin
            ptr_reg <= ptr_next;
        end
        if (cmd.finish)
        begin
            result_reg <= result_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.shift_rd;
            done_reg <= cmd.finish;
            if (cmd.finish)
            begin
                count_reg <= count_next;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/core/ils_checker.sv =====
// ----------------------------------------------------------------------------
// ils_checker
// Port-level checks of the indexed list store, bound to the top level.
// ----------------------------------------------------------------------------
module ils_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input ils_pkg::item_out_t result
);
    import ils_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.found) |-> (result.status == ST_DONE))
        else $error("found with a failing status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == ST_DONE || result.status == ST_INVALID ||
                  result.status == ST_FULL))
        else $error("undefined status code");

endmodule

bind indexed_list_store ils_checker u_ils_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// ===== tb/sv/indexed_list_store_tb.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store_tb
// Self-checking bench for the indexed list store. A shadow copy of the list
// predicts each result when an item is accepted; done results are checked
// in order. A directed opener covers empty and invalid cases, then random
// phases fill the list to capacity, drain it and wander, with varied idling.
// ----------------------------------------------------------------------------
module indexed_list_store_tb;

    import ils_pkg::*;

    localparam int CAP = CAPACITY_DEF;

    class shadow_list;
        logic [15:0] slots [CAP];
        int unsigned held = 0;
        item_out_t   due_replies [$];
        int unsigned failures = 0;

        function void put_value(int unsigned pos, logic [15:0] v);
            for (int unsigned i = held; i > pos; i--)
                slots[i] = slots[i - 1];
            slots[pos] = v;
            held++;
        endfunction

        function void note_item(item_in_t it);
            item_out_t   want;
            int unsigned pos;
            want = '0;
            pos  = it.position;
            case (it.kind)
                KIND_READ:
                    if (pos < held)
                    begin
                        want.read_data = slots[pos];
                        want.found     = 1'b1;
                    end
                    else
                        want.status = ST_INVALID;
                KIND_FRONT:
                    if (held >= CAP)
                        want.status = ST_FULL;
                    else
                        put_value(0, it.value);
                KIND_APPEND:
                    if (held >= CAP)
                        want.status = ST_FULL;
                    else
                        put_value(held, it.value);
                KIND_INSERT:
                    if (pos > held)
                        want.status = ST_INVALID;
                    else if (held >= CAP)
                        want.status = ST_FULL;
                    else
                        put_value(pos, it.value);
                KIND_DELETE:
                    if (pos < held)
                    begin
                        for (int unsigned i = pos; i + 1 < held; i++)
                            slots[i] = slots[i + 1];
                        held--;
                    end
                    else
                        want.status = ST_INVALID;
                default:
                    want.status = ST_INVALID;
            endcase
            want.entry_count = 9'(held);
            due_replies.push_back(want);
        endfunction

        function void check_result(item_out_t got);
            item_out_t want;
            if (due_replies.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: data %h found %b status %0d count %0d",
                             got.read_data, got.found, got.status, got.entry_count);
                return;
            end
            want = due_replies.pop_front();
            if (got.read_data !== want.read_data || got.found !== want.found ||
                got.status !== want.status || got.entry_count !== want.entry_count)
            begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: expected data %h found %b status %0d count %0d, %s",
                             want.read_data, want.found, want.status, want.entry_count,
                             $sformatf("got data %h found %b status %0d count %0d",
                                       got.read_data, got.found, got.status,
                                       got.entry_count));
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    item_in_t  item;
    logic      done;
    item_out_t result;

    shadow_list sb = new();

    indexed_list_store dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    initial
    begin
        #12_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic item_in_t cmd(logic [2:0] k, logic [7:0] p, logic [15:0] v);
        item_in_t it;
        it.kind     = k;
        it.position = p;
        it.value    = v;
        return it;
    endfunction

    // grow: percent of items that insert; reads 16, unknown kinds 4, rest delete
    function automatic item_in_t pick_item(int unsigned grow);
        item_in_t    it;
        int unsigned roll;
        int unsigned top;
        roll     = $urandom_range(99);
        it.value = 16'($urandom);
        if (roll < 4)
            it.kind = 3'($urandom_range(5, 7));
        else if (roll < 20)
            it.kind = KIND_READ;
        else if (roll < 20 + grow)
        begin
            case ($urandom_range(2))
                0:       it.kind = KIND_FRONT;
                1:       it.kind = KIND_APPEND;
                default: it.kind = KIND_INSERT;
            endcase
        end
        else
            it.kind = KIND_DELETE;
        if (it.kind == KIND_INSERT)
            top = sb.held;
        else
            top = (sb.held > 0) ? sb.held - 1 : 0;
        if (top > 255)
            top = 255;
        case ($urandom_range(9))
            0:       it.position = 8'($urandom);
            1:       it.position = 8'(sb.held);
            2:       it.position = 8'(top);
            default: it.position = 8'($urandom_range(top));
        endcase
        return it;
    endfunction

    task automatic send_item(input item_in_t it, input int unsigned idle_pct);
        int unsigned gap;
        gap = 0;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
            gap = $urandom_range(1, 14);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item  <= it;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(it);
    endtask

    task automatic run_random(input int unsigned n, input int unsigned grow,
                              input int unsigned idle_pct);
        for (int unsigned i = 0; i < n; i++)
            send_item(pick_item(grow), idle_pct);
    endtask

    initial
    begin
        int unsigned guard;
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, invalid positions, unknown kinds
        send_item(cmd(KIND_READ,   8'd0,   16'h1111), 0);
        send_item(cmd(KIND_DELETE, 8'd0,   16'h2222), 0);
        send_item(cmd(KIND_INSERT, 8'd1,   16'h3333), 0);
        send_item(cmd(3'd5,        8'd0,   16'hFFFF), 0);
        send_item(cmd(3'd6,        8'hFF,  16'h0000), 0);
        send_item(cmd(3'd7,        8'h55,  16'hAAAA), 0);
        // build a short list by every insert flavor
        send_item(cmd(KIND_INSERT, 8'd0,   16'hFFFF), 0);
        send_item(cmd(KIND_FRONT,  8'hFF,  16'h0000), 0);
        send_item(cmd(KIND_APPEND, 8'hAA,  16'hA5A5), 0);
        send_item(cmd(KIND_INSERT, 8'd3,   16'h5A5A), 0);
        send_item(cmd(KIND_INSERT, 8'd2,   16'h1234), 0);
        send_item(cmd(KIND_INSERT, 8'd255, 16'hBEEF), 0);
        send_item(cmd(KIND_READ,   8'd0,   16'h0000), 0);
        send_item(cmd(KIND_READ,   8'd4,   16'h0000), 0);
        send_item(cmd(KIND_READ,   8'd5,   16'h0000), 0);
        send_item(cmd(KIND_READ,   8'd255, 16'h0000), 0);
        // deletes in the middle, front and tail
        send_item(cmd(KIND_DELETE, 8'd2,   16'h0000), 0);
        send_item(cmd(KIND_DELETE, 8'd0,   16'h0000), 0);
        send_item(cmd(KIND_DELETE, 8'd2,   16'h0000), 0);
        send_item(cmd(KIND_DELETE, 8'd255, 16'h0000), 0);
        send_item(cmd(KIND_READ,   8'd1,   16'h0000), 0);
        send_item(cmd(KIND_DELETE, 8'd0,   16'h0000), 0);
        send_item(cmd(KIND_DELETE, 8'd0,   16'h0000), 0);
        send_item(cmd(KIND_READ,   8'd0,   16'h0000), 0);

        // fill to capacity and hammer the full list
        run_random(380, 80, 0);
        start <= 1'b0;
        while (sb.due_replies.size() > 0)
            @(posedge clk);
        // drain with a mostly idle sender
        run_random(350, 10, 88);
        // mixed traffic
        run_random(420, 38, 28);
        start <= 1'b0;

        guard = 0;
        while (sb.due_replies.size() > 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (16) @(posedge clk);
        sb.failures += sb.due_replies.size();
        if (sb.failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
